>>> sv/dlp_pkg.sv
// ----------------------------------------------------------------------------
// Decimal line parser package
// Shared types, codes and constants of the decimal line parser.
// ----------------------------------------------------------------------------
package dlp_pkg;

    // Line limits and field widths.
    localparam int LINE_CHARS = 10;
    localparam int CNT_W      = $clog2(LINE_CHARS + 1);
    localparam int CHAR_W     = 8;
    localparam int VALUE_W    = 31;
    localparam int STATUS_W   = 2;
    localparam int PROD_W     = VALUE_W + 4;
    localparam int PHASE_W    = 2;

    // Line parse phases.
    localparam logic [PHASE_W-1:0] PH_LEAD   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_DIGITS = 2'd1;
    localparam logic [PHASE_W-1:0] PH_TRAIL  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PARSE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_READ  = 2'd2;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_HIGH    = 8'h80;

    // One input item.
    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              end_of_file;
    } item_t;

    // One result of the parser, with its valid flag.
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
    } result_t;

endpackage

>>> sv/dlp_parser.sv
// ----------------------------------------------------------------------------
// Decimal line parser core
// Holds the line state and handles one character per cycle on which step is high.
// ----------------------------------------------------------------------------
module dlp_parser
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  dlp_pkg::item_t                  item,
    input  logic [dlp_pkg::VALUE_W-1:0]     max_value,
    output dlp_pkg::result_t                result
);

    logic [dlp_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [dlp_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [dlp_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic                        seen_reg, seen_next;
    logic                        err_reg, err_next;

    logic                        is_blank;
    logic                        is_digit;
    logic [dlp_pkg::PROD_W-1:0]  acc_wide;
    logic [dlp_pkg::PROD_W-1:0]  acc_times_ten;

    // Character classes; high bytes count as blanks.
    assign is_blank = (item.char_byte <= dlp_pkg::CH_SPACE) ||
                      (item.char_byte >= dlp_pkg::CH_HIGH);
    assign is_digit = (item.char_byte >= dlp_pkg::CH_ZERO) &&
                      (item.char_byte <= dlp_pkg::CH_NINE);

    // Accumulator times ten plus the new digit, as two shifts and two adds.
    assign acc_wide      = {{(dlp_pkg::PROD_W - dlp_pkg::VALUE_W){1'b0}}, acc_reg};
    assign acc_times_ten = (acc_wide << 3) + (acc_wide << 1) +
                           {{(dlp_pkg::PROD_W - 4){1'b0}}, item.char_byte[3:0]};

    // Next line state and the result of the current character.
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        acc_next      = acc_reg;
        seen_next     = seen_reg;
        err_next      = err_reg;
        result.valid  = 1'b0;
        result.status = dlp_pkg::ST_OK;
        result.value  = '0;

        if (step)
        begin
            if (item.end_of_file)
            begin
                result.valid  = 1'b1;
                result.status = dlp_pkg::ST_READ;
                phase_next    = dlp_pkg::PH_LEAD;
                count_next    = '0;
                acc_next      = '0;
                seen_next     = 1'b0;
                err_next      = 1'b0;
            end
            else if (item.char_byte == dlp_pkg::CH_NEWLINE)
            begin
                result.valid = 1'b1;
                if (err_reg || !seen_reg)
                begin
                    result.status = dlp_pkg::ST_PARSE;
                end
                else
                begin
                    result.value = acc_reg;
                end
                phase_next = dlp_pkg::PH_LEAD;
                count_next = '0;
                acc_next   = '0;
                seen_next  = 1'b0;
                err_next   = 1'b0;
            end
            else if (count_reg < dlp_pkg::CNT_W'(dlp_pkg::LINE_CHARS))
            begin
                count_next = count_reg + 1'b1;
                if (!err_reg)
                begin
                    if (is_blank)
                    begin
                        if (phase_reg == dlp_pkg::PH_DIGITS)
                        begin
                            phase_next = dlp_pkg::PH_TRAIL;
                        end
                    end
                    else if (is_digit && (phase_reg != dlp_pkg::PH_TRAIL))
                    begin
                        phase_next = dlp_pkg::PH_DIGITS;
                        seen_next  = 1'b1;
                        if (acc_times_ten >
                            {{(dlp_pkg::PROD_W - dlp_pkg::VALUE_W){1'b0}}, max_value})
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = acc_times_ten[dlp_pkg::VALUE_W-1:0];
                        end
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
            else
            begin
                // Line too long: every further character marks it bad.
                err_next = 1'b1;
            end
        end
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dlp_pkg::PH_LEAD;
            count_reg <= '0;
            acc_reg   <= '0;
            seen_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> sv/decimal_line_parser_unit.sv
// ----------------------------------------------------------------------------
// Decimal line parser unit
// Parses lines of one unsigned decimal number from a character stream.
// ----------------------------------------------------------------------------
// A result is registered from the newline or end-of-file item that causes it
// once that item has passed the input register and the parser step.
// Throughput: one character per cycle while the output takes results, through
// the combinational parser step between the input register and the result
// register; a result held by a stalled output also holds the input.
// Reset (rst_n low, asynchronous): line state cleared, max_value set to its
// largest value, both stream registers empty.
module decimal_line_parser_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] char_byte
    input  logic                            s_tuser,   // [0] end_of_file
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [30:0] value, [31] zero
    output logic [1:0]                      m_tuser,   // [1:0] status
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dlp_pkg::VALUE_W-1:0]     cfg_data   // max_value
);

    logic                           in_vld_reg, in_vld_next;
    dlp_pkg::item_t                 in_item_reg;
    logic                           out_vld_reg, out_vld_next;
    logic [dlp_pkg::STATUS_W-1:0]   out_status_reg;
    logic [dlp_pkg::VALUE_W-1:0]    out_value_reg;
    logic [dlp_pkg::VALUE_W-1:0]    max_value_reg;
    logic                           step;
    dlp_pkg::result_t               result;

    // The held item moves on when the result register can take its result.
    assign step     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || step;
    assign cfg_ready = 1'b1;

    assign in_vld_next  = s_tready ? s_tvalid : in_vld_reg;
    assign out_vld_next = step ? result.valid : (out_vld_reg && !m_tready);

    // Valid flags of the input and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Input payload, captured on each transfer.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.char_byte   <= s_tdata;
            in_item_reg.end_of_file <= s_tuser;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (step && result.valid)
        begin
            out_status_reg <= result.status;
            out_value_reg  <= result.value;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_value_reg <= cfg_data;
        end
    end

    // Parser core with the line state.
    dlp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_item_reg),
        .max_value (max_value_reg),
        .result    (result)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_value_reg};
    assign m_tuser  = out_status_reg;

endmodule
